FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the keypad scanner checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("keypad scanner assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("keypad scanner assertion failed");

`endif

FILE: design/akps_pkg.sv
// ----------------------------------------------------------------------------
// akps_pkg
// Types and constants shared by the ADC ladder keypad scanner modules.
// ----------------------------------------------------------------------------
package akps_pkg;

	localparam int SlotsMax  = 12;
	localparam int SlotW     = 16;
	localparam int NominalW  = 11;
	localparam int CodeW     = 5;
	localparam int TableW    = SlotsMax * SlotW;

	// window top is capped here
	localparam logic [11:0] AdcFull = 12'd1024;
	// previous raw key after reset: matches no key
	localparam logic [CodeW-1:0] NoKey = 5'd31;

	// register reset values
	localparam logic [29:0] SpecialRst  = 30'd518423626;
	localparam logic [9:0]  DevRst      = 10'd20;
	localparam logic [7:0]  LongRst     = 8'd15;
	localparam logic [7:0]  PowerOffRst = 8'd30;
	localparam logic [31:0] RepeatRst   = 32'd32768150;

	// configuration register indexes
	localparam logic [2:0] RegKeyLow   = 3'd0;
	localparam logic [2:0] RegKeyMid   = 3'd1;
	localparam logic [2:0] RegKeyHigh  = 3'd2;
	localparam logic [2:0] RegSpecial  = 3'd3;
	localparam logic [2:0] RegDev      = 3'd4;
	localparam logic [2:0] RegLong     = 3'd5;
	localparam logic [2:0] RegPowerOff = 3'd6;
	localparam logic [2:0] RegRepeat   = 3'd7;

	// event kinds
	localparam logic [1:0] KindPressed  = 2'd0;
	localparam logic [1:0] KindReleased = 2'd1;
	localparam logic [1:0] KindContinue = 2'd2;

	typedef struct packed {
		logic [TableW-1:0] key_table;
		logic [29:0]       special_codes;
		logic [9:0]        deviation;
		logic [7:0]        long_limit;
		logic [7:0]        poweroff_limit;
		logic [31:0]       repeat_timing;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [CodeW-1:0] key;
		logic             valid;
	} evt_t;

endpackage

FILE: design/adc_ladder_keypad_scanner_core.sv
// ----------------------------------------------------------------------------
// adc_ladder_keypad_scanner_core
// ADC resistor-ladder keypad scanner with debounce, long press and repeat.
// ----------------------------------------------------------------------------
// One input beat is one scan (ADC sample and millisecond time) and gives
// exactly one output beat. The block sustains one scan per clock cycle
// while the output takes its results; a result passes through the input
// register, the key register after the window comparators and the result register.
// Each pipeline register stalls independently, so input beats are still
// taken while a result waits on the output, until the input and key
// registers are both full. No clearing pass after reset.
// Write configuration only while the scanner is idle.
module adc_ladder_keypad_scanner_core #(
	parameter int TABLE_SLOTS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// scan input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // adc_sample[10:0], time_ms[42:11], zero fill
	// event output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // event_valid[0], event_key[5:1], event_kind[7:6]
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	akps_pkg::cfg_t              cfg;
	logic                        vld_s1;
	logic [akps_pkg::NominalW-1:0] sample_s1;
	logic [31:0]                 time_s1;
	logic                        vld_s2;
	logic [akps_pkg::CodeW-1:0]  key_s2;
	logic [31:0]                 time_s2;
	logic                        out_vld_q;
	akps_pkg::evt_t              result_q;
	logic [akps_pkg::CodeW-1:0]  raw_key;
	akps_pkg::evt_t              evt;
	logic                        rdy_out;
	logic                        rdy_s2;
	logic                        rdy_s1;
	logic                        go;

	akps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// per-stage flow control
	assign rdy_out  = !out_vld_q || m_tready;
	assign rdy_s2   = !vld_s2 || rdy_out;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign go       = vld_s2 && rdy_out;
	assign s_tready = rdy_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (rdy_s1)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			sample_s1 <= s_tdata[10:0];
			time_s1   <= s_tdata[42:11];
		end
	end

	akps_matcher #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_matcher (
		.key_table (cfg.key_table),
		.deviation (cfg.deviation),
		.sample    (sample_s1),
		.key       (raw_key)
	);

	// raw key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (rdy_s2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			key_s2  <= raw_key;
			time_s2 <= time_s1;
		end
	end

	akps_event u_event (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.key     (key_s2),
		.time_ms (time_s2),
		.cfg     (cfg),
		.evt     (evt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (rdy_out)
			out_vld_q <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (go)
			result_q <= evt;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = result_q;

endmodule

FILE: design/akps_cfg.sv
// ----------------------------------------------------------------------------
// akps_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module akps_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output akps_pkg::cfg_t      cfg
);

	akps_pkg::cfg_t cfg_q;

	// register writes, one index per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_table      <= '0;
			cfg_q.special_codes  <= akps_pkg::SpecialRst;
			cfg_q.deviation      <= akps_pkg::DevRst;
			cfg_q.long_limit     <= akps_pkg::LongRst;
			cfg_q.poweroff_limit <= akps_pkg::PowerOffRst;
			cfg_q.repeat_timing  <= akps_pkg::RepeatRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				akps_pkg::RegKeyLow:   cfg_q.key_table[63:0]    <= cfg_data;
				akps_pkg::RegKeyMid:   cfg_q.key_table[127:64]  <= cfg_data;
				akps_pkg::RegKeyHigh:  cfg_q.key_table[191:128] <= cfg_data;
				akps_pkg::RegSpecial:  cfg_q.special_codes      <= cfg_data[29:0];
				akps_pkg::RegDev:      cfg_q.deviation          <= cfg_data[9:0];
				akps_pkg::RegLong:     cfg_q.long_limit         <= cfg_data[7:0];
				akps_pkg::RegPowerOff: cfg_q.poweroff_limit     <= cfg_data[7:0];
				akps_pkg::RegRepeat:   cfg_q.repeat_timing      <= cfg_data[31:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/akps_matcher.sv
// ----------------------------------------------------------------------------
// akps_matcher
// Parallel window comparators: maps one ADC sample to a raw key code.
// ----------------------------------------------------------------------------
module akps_matcher #(
	parameter int TABLE_SLOTS = 12
) (
	input  logic [akps_pkg::TableW-1:0]  key_table,
	input  logic [9:0]                   deviation,
	input  logic [akps_pkg::NominalW-1:0] sample,
	output logic [akps_pkg::CodeW-1:0]   key
);

	// one comparator per slot; the last matching slot wins
	always_comb begin
		logic [akps_pkg::NominalW-1:0] nominal;
		logic [akps_pkg::CodeW-1:0]    code;
		logic [akps_pkg::NominalW-1:0] lo;
		logic [11:0]                   hi;
		nominal = '0;
		code    = '0;
		lo      = '0;
		hi      = '0;
		key     = '0;
		for (int s = 0; s < TABLE_SLOTS; s++) begin
			nominal = key_table[s*akps_pkg::SlotW +: akps_pkg::NominalW];
			code    = key_table[s*akps_pkg::SlotW + akps_pkg::NominalW +: akps_pkg::CodeW];
			// bottom floored at zero
			if (nominal <= {1'b0, deviation})
				lo = '0;
			else
				lo = nominal - {1'b0, deviation};
			// top capped at full scale
			hi = {1'b0, nominal} + {2'b00, deviation};
			if (hi > akps_pkg::AdcFull)
				hi = akps_pkg::AdcFull;
			if (code != '0 && sample >= lo && {1'b0, sample} <= hi)
				key = code;
		end
	end

endmodule

FILE: design/akps_event.sv
// ----------------------------------------------------------------------------
// akps_event
// Debounce, short/long press stages, event generation and repeat timing.
// ----------------------------------------------------------------------------
module akps_event (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [akps_pkg::CodeW-1:0]  key,
	input  logic [31:0]                 time_ms,
	input  akps_pkg::cfg_t              cfg,
	output akps_pkg::evt_t              evt
);

	typedef struct packed {
		logic [akps_pkg::CodeW-1:0] val;
		logic [7:0]                 cnt;
	} hold_t;

	logic [akps_pkg::CodeW-1:0] prev_key_q;
	logic [1:0]                 stable_q;
	logic [7:0]                 ok_cnt_q;
	logic [7:0]                 photo_cnt_q;
	logic [7:0]                 power_cnt_q;
	logic [akps_pkg::CodeW-1:0] reported_q;
	logic [31:0]                deadline_q;

	logic [1:0]                 stable_inc;
	logic                       debounced;
	hold_t                      ok_h;
	hold_t                      photo_h;
	hold_t                      power_h;
	logic [akps_pkg::CodeW-1:0] val;
	logic [31:0]                since;
	logic                       repeat_due;
	logic [31:0]                deadline_d;

	// one short/long stage: counts while held, passes a short press on release
	function automatic hold_t hold_stage(
		input logic [akps_pkg::CodeW-1:0] v,
		input logic [akps_pkg::CodeW-1:0] code,
		input logic [akps_pkg::CodeW-1:0] long_code,
		input logic [7:0]                 limit,
		input logic [7:0]                 cnt
	);
		hold_t r;
		r.val = v;
		r.cnt = cnt;
		if (v == code) begin
			if (cnt < limit)
				r.cnt = cnt + 8'd1;
			r.val = (r.cnt >= limit) ? long_code : '0;
		end else begin
			if (cnt != 8'd0 && cnt < limit)
				r.val = code;
			r.cnt = '0;
		end
		return r;
	endfunction

	// debounce: every second identical scan
	assign stable_inc = (key == prev_key_q) ? stable_q + 2'd1 : 2'd1;
	assign debounced  = stable_inc >= 2'd2;

	// ok, photo and power stages chained in that order
	assign ok_h    = hold_stage(key, cfg.special_codes[4:0], cfg.special_codes[19:15],
		cfg.long_limit, ok_cnt_q);
	assign photo_h = hold_stage(ok_h.val, cfg.special_codes[9:5], cfg.special_codes[24:20],
		cfg.long_limit, photo_cnt_q);
	assign power_h = hold_stage(photo_h.val, cfg.special_codes[14:10],
		cfg.special_codes[29:25], cfg.poweroff_limit, power_cnt_q);
	assign val     = power_h.val;

	// repeat timing
	assign since      = time_ms - deadline_q;
	assign repeat_due = (time_ms > deadline_q) && (since >= {16'd0, cfg.repeat_timing[15:0]});

	// event decode
	always_comb begin
		evt        = '0;
		deadline_d = deadline_q;
		if (debounced) begin
			if (val != reported_q) begin
				evt.valid  = 1'b1;
				evt.key    = (val != '0) ? val : reported_q;
				evt.kind   = (val != '0) ? akps_pkg::KindPressed : akps_pkg::KindReleased;
				deadline_d = time_ms + {16'd0, cfg.repeat_timing[31:16]};
			end else if (val != '0 && repeat_due) begin
				evt.valid  = 1'b1;
				evt.key    = val;
				evt.kind   = akps_pkg::KindContinue;
				deadline_d = time_ms;
			end
		end
	end

	// scanner state, updated once per scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q  <= akps_pkg::NoKey;
			stable_q    <= '0;
			ok_cnt_q    <= '0;
			photo_cnt_q <= '0;
			power_cnt_q <= '0;
			reported_q  <= '0;
			deadline_q  <= '0;
		end else if (go) begin
			prev_key_q <= key;
			stable_q   <= debounced ? 2'd0 : stable_inc;
			if (debounced) begin
				ok_cnt_q    <= ok_h.cnt;
				photo_cnt_q <= photo_h.cnt;
				power_cnt_q <= power_h.cnt;
				reported_q  <= val;
				deadline_q  <= deadline_d;
			end
		end
	end

endmodule

FILE: design/akps_checker.sv
// ----------------------------------------------------------------------------
// akps_checker
// Port-level checks on the keypad scanner's event stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module akps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// no event means key and kind are zero
	`ASSERT_SAME(a_idle_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[7:1] == 7'd0)

	// an event always names a key
	`ASSERT_SAME(a_evt_key, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[5:1] != 5'd0)

	// the kind code is one of pressed, released, continue
	`ASSERT_SAME(a_kind_code, clk, arst_n, m_tvalid, m_tdata[7:6] != 2'd3)

endmodule

bind adc_ladder_keypad_scanner_core akps_checker u_akps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the ADC ladder keypad scanner core. Scans are driven
// in bursts with random gaps while the event side stalls on its own pattern.
// A scoreboard predicts the event of every accepted scan (window match,
// debounce, short/long press stages, repeat timing) and checks each event
// beat in order. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CycleLimit = 300000;
	localparam int HoldoffCycles = 80;

	// ------------------------------------------------------------------------
	// Event predictor and in-order checker
	// ------------------------------------------------------------------------
	class keypad_scoreboard;
		// register copies
		logic [63:0] table_word [3];
		logic [29:0] codes;
		logic [9:0]  dev;
		logic [7:0]  long_lim;
		logic [7:0]  off_lim;
		logic [31:0] rep_timing;
		// scanner state
		logic [4:0]  last_raw;
		logic [1:0]  stable;
		logic [7:0]  hold_cnt [3];
		logic [4:0]  shown_key;
		logic [31:0] deadline;
		akps_pkg::evt_t expected_events [$];
		int          errors;
		int          scans;
		int          kinds_seen [3];

		function new();
			table_word = '{64'd0, 64'd0, 64'd0};
			codes      = akps_pkg::SpecialRst;
			dev        = akps_pkg::DevRst;
			long_lim   = akps_pkg::LongRst;
			off_lim    = akps_pkg::PowerOffRst;
			rep_timing = akps_pkg::RepeatRst;
			last_raw   = akps_pkg::NoKey;
			stable     = '0;
			hold_cnt   = '{8'd0, 8'd0, 8'd0};
			shown_key  = '0;
			deadline   = '0;
			errors     = 0;
			scans      = 0;
			kinds_seen = '{0, 0, 0};
		endfunction

		function void apply_reg(input logic [2:0] idx, input logic [63:0] d);
			case (idx)
				akps_pkg::RegKeyLow:   table_word[0] = d;
				akps_pkg::RegKeyMid:   table_word[1] = d;
				akps_pkg::RegKeyHigh:  table_word[2] = d;
				akps_pkg::RegSpecial:  codes = d[29:0];
				akps_pkg::RegDev:      dev = d[9:0];
				akps_pkg::RegLong:     long_lim = d[7:0];
				akps_pkg::RegPowerOff: off_lim = d[7:0];
				akps_pkg::RegRepeat:   rep_timing = d[31:0];
				default: ;
			endcase
		endfunction

		// last matching slot wins; unused slots and empty windows never match
		function logic [4:0] decode_adc(input logic [10:0] adc);
			logic [15:0] slot;
			logic [4:0]  key;
			int          lo, hi;
			key = '0;
			for (int s = 0; s < akps_pkg::SlotsMax; s++) begin
				slot = table_word[s / 4][(s % 4) * 16 +: 16];
				lo = (slot[10:0] <= dev) ? 0 : int'(slot[10:0]) - int'(dev);
				hi = int'(slot[10:0]) + int'(dev);
				if (hi > int'(akps_pkg::AdcFull))
					hi = int'(akps_pkg::AdcFull);
				if (slot[15:11] != 0 && int'(adc) >= lo && int'(adc) <= hi)
					key = slot[15:11];
			end
			return key;
		endfunction

		// one short/long press stage, n selects the hold counter
		function logic [4:0] press_stage(input logic [4:0] v, input logic [4:0] code,
				input logic [4:0] long_code, input logic [7:0] lim, input int n);
			if (v == code) begin
				if (hold_cnt[n] < lim)
					hold_cnt[n] = hold_cnt[n] + 8'd1;
				return (hold_cnt[n] >= lim) ? long_code : 5'd0;
			end
			// short press shows up on release
			if (hold_cnt[n] > 0 && hold_cnt[n] < lim)
				v = code;
			hold_cnt[n] = '0;
			return v;
		endfunction

		function void predict_scan(input logic [10:0] adc, input logic [31:0] now);
			logic [4:0]     key, val;
			akps_pkg::evt_t ev;
			key = decode_adc(adc);
			ev = '0;
			scans++;
			if (key != last_raw) begin
				last_raw = key;
				stable = 2'd1;
			end else begin
				stable = stable + 2'd1;
			end
			if (stable >= 2'd2) begin
				stable = '0;
				val = press_stage(key, codes[4:0], codes[19:15], long_lim, 0);
				val = press_stage(val, codes[9:5], codes[24:20], long_lim, 1);
				val = press_stage(val, codes[14:10], codes[29:25], off_lim, 2);
				if (val != shown_key) begin
					ev.valid = 1'b1;
					if (val != 0) begin
						ev.key = val;
						ev.kind = akps_pkg::KindPressed;
					end else begin
						ev.key = shown_key;
						ev.kind = akps_pkg::KindReleased;
					end
					shown_key = val;
					deadline = now + {16'd0, rep_timing[31:16]};
				end else if (val != 0) begin
					if (now > deadline && now - deadline >= {16'd0, rep_timing[15:0]}) begin
						deadline = now;
						ev.valid = 1'b1;
						ev.key = val;
						ev.kind = akps_pkg::KindContinue;
					end
				end
			end
			expected_events.push_back(ev);
		endfunction

		function void field_check(input string name, input logic [4:0] want,
				input logic [4:0] got);
			if (got !== want) begin
				$display("%0t: event %s mismatch, expected %0d, got %0d", $time, name,
					want, got);
				errors++;
			end
		endfunction

		function void check_event(input logic [7:0] beat);
			akps_pkg::evt_t got, want;
			got = beat;
			if (expected_events.size() == 0) begin
				$display("%0t: event beat %h arrived, expected none", $time, beat);
				errors++;
				return;
			end
			want = expected_events.pop_front();
			field_check("valid", {4'd0, want.valid}, {4'd0, got.valid});
			field_check("key", want.key, got.key);
			field_check("kind", {3'd0, want.kind}, {3'd0, got.kind});
			if (want.valid && want.kind <= akps_pkg::KindContinue)
				kinds_seen[want.kind]++;
		endfunction

		function int backlog();
			return expected_events.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and signals
	// ------------------------------------------------------------------------
	bit          clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = akps_pkg::RegKeyLow;
	logic [63:0] cfg_data = '0;

	adc_ladder_keypad_scanner_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	keypad_scoreboard sb;

	// keypad layout mirrored for picking samples
	logic [10:0] nominal_of [12];
	logic [4:0]  code_of [12];
	int          cur_dev, cur_long, cur_off;
	logic [31:0] clock_ms = '0;
	int          step_ms = 4;
	int          burst_left = 0;
	int          settings_used = 0;
	int          cycle_count = 0;
	// receiver pattern and long hold-off
	int          holdoff_requests = 0;
	int          holdoff_seen = 0;
	int          holdoff_left = 0;
	int          rx_mode = 0;
	int          rx_seg = 0;

	always begin
		clk = 1'b0;
		#6 clk = 1'b1;
		#6;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: run limit reached with %0d events outstanding", $time,
				sb.backlog());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// event side: stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left--;
			m_tready <= 1'b0;
		end else if (holdoff_seen != holdoff_requests) begin
			holdoff_seen = holdoff_requests;
			holdoff_left = HoldoffCycles;
			m_tready <= 1'b0;
		end else begin
			if (rx_seg == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_seg = $urandom_range(20, 150);
			end
			rx_seg--;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_seg % 4 == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// event checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_event(m_tdata);
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// one scan beat; the sender may idle between bursts
	task automatic push_scan(input logic [10:0] adc, input logic [31:0] now);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, now, adc};
		do @(posedge clk); while (!s_tready);
		sb.predict_scan(adc, now);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic scan(input logic [10:0] adc, input logic [31:0] dt);
		clock_ms = clock_ms + dt;
		push_scan(adc, clock_ms);
	endtask

	// stop sending and let every outstanding event drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.backlog() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.apply_reg(idx, d);
		@(negedge clk);
	endtask

	// write every register: key table from the layout arrays, then the rest
	task automatic configure(input logic [29:0] codes, input int dev, input int long_lim,
			input int off_lim, input logic [31:0] rep);
		logic [63:0] word;
		wait_idle();
		for (int w = 0; w < 3; w++) begin
			for (int k = 0; k < 4; k++)
				word[k * 16 +: 16] = {code_of[w * 4 + k], nominal_of[w * 4 + k]};
			write_reg((w == 0) ? akps_pkg::RegKeyLow :
				(w == 1) ? akps_pkg::RegKeyMid : akps_pkg::RegKeyHigh, word);
		end
		write_reg(akps_pkg::RegSpecial, {34'd0, codes});
		write_reg(akps_pkg::RegDev, 64'(dev));
		write_reg(akps_pkg::RegLong, 64'(long_lim));
		write_reg(akps_pkg::RegPowerOff, 64'(off_lim));
		write_reg(akps_pkg::RegRepeat, {32'd0, rep});
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_dev = dev;
		cur_long = long_lim;
		cur_off = off_lim;
		settings_used++;
	endtask

	function automatic logic [29:0] pack_codes(input logic [4:0] ok, input logic [4:0] photo,
			input logic [4:0] power, input logic [4:0] long_ok, input logic [4:0] long_photo,
			input logic [4:0] power_off);
		return {power_off, long_photo, long_ok, power, photo, ok};
	endfunction

	// spaced layout with codes drawn mostly from the given pool
	function automatic void fill_layout(input logic [4:0] a, input logic [4:0] b,
			input logic [4:0] c, input bit clear_low);
		for (int s = 0; s < akps_pkg::SlotsMax; s++) begin
			nominal_of[s] = 11'(s * 80 + $urandom_range(0, 60));
			if ($urandom_range(0, 9) == 0)
				nominal_of[s] = 11'($urandom_range(1025, 2047));
			case ($urandom_range(0, 4))
				0: code_of[s] = a;
				1: code_of[s] = b;
				2: code_of[s] = c;
				3: code_of[s] = 5'($urandom_range(1, 31));
				default: code_of[s] = '0;
			endcase
			if (clear_low && s < 4) begin
				nominal_of[s] = '0;
				code_of[s] = '0;
			end
		end
	endfunction

	// a reading near a slot, sometimes just outside its window
	function automatic logic [10:0] sample_for_slot(input int s);
		int v;
		case ($urandom_range(0, 5))
			0: v = int'(nominal_of[s]) - cur_dev - 1;
			1: v = int'(nominal_of[s]) + cur_dev + 1;
			default: v = int'(nominal_of[s]) + int'($urandom_range(0, 2 * cur_dev)) - cur_dev;
		endcase
		if (v < 0)
			v = 0;
		if (v > 2047)
			v = 2047;
		return 11'(v);
	endfunction

	// mostly press/hold/release gestures, plus bounce and noise
	task automatic random_phase(input int n);
		int done, len, gesture, slot, cap;
		done = 0;
		cap = 2 * ((cur_long > cur_off) ? cur_long : cur_off) + 6;
		if (cap > 70)
			cap = 70;
		while (done < n) begin
			gesture = $urandom_range(0, 9);
			slot = $urandom_range(0, 11);
			len = $urandom_range(1, cap);
			if (gesture < 8) begin
				repeat (len) scan(sample_for_slot(slot), $urandom_range(0, step_ms));
				done += len;
				// key change with no release between
				if (gesture >= 6) begin
					slot = $urandom_range(0, 11);
					len = $urandom_range(1, cap);
					repeat (len) scan(sample_for_slot(slot), $urandom_range(0, step_ms));
					done += len;
				end
				len = $urandom_range(1, 4);
				repeat (len) scan(11'($urandom_range(1025, 2047)), $urandom_range(0, step_ms));
				done += len;
			end else if (gesture == 8) begin
				// contact bounce across slots
				len = $urandom_range(2, 8);
				repeat (len) scan(sample_for_slot($urandom_range(0, 11)),
					$urandom_range(0, step_ms));
				done += len;
			end else begin
				// any reading at any time
				clock_ms = $urandom();
				len = $urandom_range(1, 4);
				repeat (len) scan(11'($urandom_range(0, 2047)), 32'd0);
				done += len;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [4:0] a, b, c;
		sb = new();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fixed layout: ok, photo, power, then plain keys; one unused slot
		// and one slot whose window is empty
		for (int s = 0; s < akps_pkg::SlotsMax; s++) begin
			nominal_of[s] = 11'(100 * (s + 1));
			code_of[s] = 5'(s);
		end
		code_of[0] = 5'd10;
		code_of[1] = 5'd2;
		code_of[2] = 5'd1;
		nominal_of[9] = 11'd1010;
		nominal_of[10] = 11'd10;
		code_of[10] = 5'd0;
		nominal_of[11] = 11'd1200;
		code_of[11] = 5'd12;
		configure(pack_codes(5'd10, 5'd2, 5'd1, 5'd13, 5'd14, 5'd15), 20, 2, 2,
			{16'd10, 16'd5});

		// directed scans
		clock_ms = '0;
		repeat (2) scan(11'd0, 32'd0);       // unused slot only: nothing
		repeat (2) scan(11'd1024, 32'd3);    // top of capped window
		repeat (2) scan(11'd1025, 32'd3);    // just above the cap: release
		repeat (2) scan(11'd1200, 32'd3);    // empty window
		repeat (2) scan(11'd500, 32'd3);     // plain press
		repeat (2) scan(11'd600, 32'd3);     // other key, no release
		repeat (4) scan(11'd600, 32'd8);     // continue after delay/interval
		repeat (2) scan(11'd2047, 32'd3);
		repeat (2) scan(11'd100, 32'd3);     // short ok press
		repeat (2) scan(11'd2047, 32'd3);    // reported on release
		repeat (2) scan(11'd2047, 32'd3);
		scan(11'd2047, 32'hFFFF_FFFF - clock_ms);

		// low extremes: exact windows, limits of one, no repeat delay
		step_ms = 3;
		configure(pack_codes(5'd10, 5'd2, 5'd1, 5'd13, 5'd14, 5'd15), 0, 1, 1, 32'd0);
		random_phase(90);

		// high extremes: full overlap, longest limits, longest repeat delay and interval
		for (int s = 0; s < 8; s++) begin
			nominal_of[s] = 11'($urandom_range(0, 1023));
			code_of[s] = 5'($urandom_range(1, 31));
		end
		for (int s = 8; s < akps_pkg::SlotsMax; s++) begin
			nominal_of[s] = 11'h7FF;
			code_of[s] = 5'd31;
		end
		clock_ms = $urandom();
		step_ms = 100000;
		configure(30'h3FFF_FFFF, 1023, 255, 255, 32'hFFFF_FFFF);
		random_phase(70);

		// shared and chained special codes, time wrapping through zero
		a = 5'($urandom_range(1, 31));
		b = 5'($urandom_range(1, 31));
		c = 5'($urandom_range(1, 31));
		fill_layout(a, b, c, 1'b0);
		clock_ms = 32'hFFFF_FF00;
		step_ms = 8;
		configure(pack_codes(a, a, b, b, c, a), $urandom_range(10, 40), $urandom_range(1, 5),
			$urandom_range(1, 5), {16'($urandom_range(0, 30)), 16'($urandom_range(0, 20))});
		random_phase(100);

		// random codes from the layout, low slots cleared, long output stall
		a = 5'($urandom_range(1, 31));
		b = 5'($urandom_range(1, 31));
		c = 5'($urandom_range(1, 31));
		fill_layout(a, b, c, 1'b1);
		step_ms = 10;
		configure(pack_codes(a, b, c, code_of[$urandom_range(4, 11)],
			code_of[$urandom_range(4, 11)], code_of[$urandom_range(4, 11)]),
			$urandom_range(0, 80), $urandom_range(1, 8), $urandom_range(1, 8),
			{16'($urandom_range(0, 40)), 16'($urandom_range(0, 25))});
		holdoff_requests++;
		random_phase(100);

		// everything random
		for (int s = 0; s < akps_pkg::SlotsMax; s++) begin
			nominal_of[s] = 11'($urandom_range(0, 2047));
			code_of[s] = 5'($urandom_range(0, 31));
		end
		step_ms = $urandom_range(1, 2000);
		configure(30'($urandom()), $urandom_range(0, 1023), $urandom_range(1, 255),
			$urandom_range(1, 255), $urandom());
		random_phase(90);

		wait_idle();
		repeat (10) @(negedge clk);
		$display("Covered %0d scans over %0d register settings", sb.scans, settings_used);
		$display("Events checked: %0d pressed, %0d released, %0d continue",
			sb.kinds_seen[akps_pkg::KindPressed], sb.kinds_seen[akps_pkg::KindReleased],
			sb.kinds_seen[akps_pkg::KindContinue]);
		if (sb.errors == 0 && sb.backlog() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
